[rtl/core/nnis_pkg.sv]
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and codes for the nearest-neighbor image scaler core.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

    localparam int CFG_BITS      = 9;
    localparam int CFG_ADDR_BITS = 2;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

[rtl/core/nnis_ram.sv]
// ----------------------------------------------------------------------------
// nnis_ram
// Single-port RAM with registered read and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/nnis_div.sv]
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle; results hold until restart.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_div #(
    parameter int DW = 9
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DW-1:0]        dividend,
    input  wire logic [DW-1:0]        divisor,
    output logic      [DW-1:0]        quotient,
    output logic      [DW-1:0]        remainder,
    output nnis_pkg::div_status_t     status
);

    localparam int CW = $clog2(DW + 1);

    logic          active_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] den_reg;

    logic [DW:0]   shifted;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] quo_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        ge       = shifted >= {1'b0, den_reg};
        diff     = shifted - {1'b0, den_reg};
        rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= CW'(DW);
            end else if (active_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= divisor;
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (active_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = active_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

[rtl/core/nearest_neighbor_image_scaler_core.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Nearest-neighbor grayscale resizer: loads a source frame in raster order,
// answers each request with the next output pixel in raster order.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | content
//  s_       | in        | s_tvalid/s_tready  | tuser command, tdata source pixel
//  m_       | out       | m_tvalid/m_tready  | tdata output pixel, tlast last pixel
//  cfg_     | in        | cfg_wr_en          | cfg_addr register index, cfg_wdata
//
//  One item per cycle while s_tready is high; a request's pixel appears in the cycle after acceptance,
//  read through the registered port of the frame store.
//  After reset and after each register write, s_tready stays low while the
//  per-axis step quotient and remainder are computed by the DW-bit
//  shift-subtract dividers (DW = bits of MAX_DIM). No clearing pass.
//  Both item kinds wait while an output pixel is held by m_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_scaler_core #(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]       s_tdata,   // source_pixel
    input  wire logic                                  s_tuser,   // command

    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((PIXEL_BITS+7)/8)*8-1:0]       m_tdata,   // out_pixel
    output logic                                       m_tlast,

    input  wire logic                                  cfg_wr_en,
    input  wire logic [nnis_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire logic [nnis_pkg::CFG_BITS-1:0]         cfg_wdata
);

    localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    function automatic logic [DW-1:0] eff_dim(input logic [nnis_pkg::CFG_BITS-1:0] v);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DW'(MAX_DIM);
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    logic [nnis_pkg::CFG_BITS-1:0] src_width_reg;
    logic [nnis_pkg::CFG_BITS-1:0] src_height_reg;
    logic [nnis_pkg::CFG_BITS-1:0] dst_width_reg;
    logic [nnis_pkg::CFG_BITS-1:0] dst_height_reg;

    logic              kick_reg;
    logic              cfg_ready_reg;
    logic [CNT_W-1:0]  frame_size_reg;

    logic [CNT_W-1:0]  load_count_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  src_col_reg;
    logic [POS_W-1:0]  src_row_reg;
    logic [DW-1:0]     col_rem_reg;
    logic [DW-1:0]     row_rem_reg;
    logic              m_tvalid_reg;
    logic              m_tlast_reg;

    logic [DW-1:0]     sw, sh, dw, dh;
    logic [DW-1:0]     col_q, col_r, row_q, row_r;
    nnis_pkg::div_status_t col_st, row_st;

    logic              accept;
    logic              is_load;
    logic              is_req;
    logic              load_ok;
    logic              col_wrap;
    logic              row_wrap;
    logic              last;
    logic [DW:0]       col_rsum, row_rsum;
    logic              col_carry, row_carry;
    logic [POS_W-1:0]  src_col_next, src_row_next;
    logic [DW-1:0]     col_rem_next, row_rem_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIXEL_BITS-1:0] ram_rdata;

    assign sw = eff_dim(src_width_reg);
    assign sh = eff_dim(src_height_reg);
    assign dw = eff_dim(dst_width_reg);
    assign dh = eff_dim(dst_height_reg);

    nnis_div #(.DW(DW)) u_div_col (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (kick_reg),
        .dividend  (sw),
        .divisor   (dw),
        .quotient  (col_q),
        .remainder (col_r),
        .status    (col_st)
    );

    nnis_div #(.DW(DW)) u_div_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (kick_reg),
        .dividend  (sh),
        .divisor   (dh),
        .quotient  (row_q),
        .remainder (row_r),
        .status    (row_st)
    );

    always_comb begin
        s_tready = cfg_ready_reg && !kick_reg && !col_st.busy && !row_st.busy
                   && (!m_tvalid_reg || m_tready);
        accept   = s_tvalid && s_tready;
        is_load  = accept && (s_tuser == nnis_pkg::CMD_LOAD);
        is_req   = accept && (s_tuser == nnis_pkg::CMD_REQUEST);
        load_ok  = load_count_reg < frame_size_reg;

        col_wrap = (DW'(out_col_reg) + DW'(1)) >= dw;
        row_wrap = (DW'(out_row_reg) + DW'(1)) >= dh;
        last     = col_wrap && row_wrap;

        col_rsum     = (DW+1)'(col_rem_reg) + (DW+1)'(col_r);
        col_carry    = col_rsum >= (DW+1)'(dw);
        col_rem_next = col_carry ? DW'(col_rsum - (DW+1)'(dw)) : DW'(col_rsum);
        src_col_next = POS_W'((DW+1)'(src_col_reg) + (DW+1)'(col_q)
                              + (DW+1)'(col_carry));

        row_rsum     = (DW+1)'(row_rem_reg) + (DW+1)'(row_r);
        row_carry    = row_rsum >= (DW+1)'(dh);
        row_rem_next = row_carry ? DW'(row_rsum - (DW+1)'(dh)) : DW'(row_rsum);
        src_row_next = POS_W'((DW+1)'(src_row_reg) + (DW+1)'(row_q)
                              + (DW+1)'(row_carry));

        rd_addr  = ADDR_W'((POS_W+DW)'(src_row_reg) * (POS_W+DW)'(sw)
                           + (POS_W+DW)'(src_col_reg));
        ram_addr = is_load ? load_count_reg[ADDR_W-1:0] : rd_addr;
    end

    nnis_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_frame_store (
        .aclk  (aclk),
        .we    (is_load && load_ok),
        .re    (is_req),
        .addr  (ram_addr),
        .wdata (s_tdata[PIXEL_BITS-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        frame_size_reg <= CNT_W'(sw) * CNT_W'(sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= nnis_pkg::CFG_BITS'(256);
            src_height_reg <= nnis_pkg::CFG_BITS'(256);
            dst_width_reg  <= nnis_pkg::CFG_BITS'(256);
            dst_height_reg <= nnis_pkg::CFG_BITS'(256);
            kick_reg       <= 1'b1;
            cfg_ready_reg  <= 1'b0;
            load_count_reg <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            col_rem_reg    <= '0;
            row_rem_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end else begin
            kick_reg <= 1'b0;
            if (col_st.done && row_st.done && !kick_reg) begin
                cfg_ready_reg <= 1'b1;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (nnis_pkg::cfg_reg_t'(cfg_addr))
                    nnis_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata;
                    nnis_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_wdata;
                    nnis_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_wdata;
                    nnis_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_wdata;
                    default: ;
                endcase
                kick_reg       <= 1'b1;
                cfg_ready_reg  <= 1'b0;
                load_count_reg <= '0;
                out_col_reg    <= '0;
                out_row_reg    <= '0;
                src_col_reg    <= '0;
                src_row_reg    <= '0;
                col_rem_reg    <= '0;
                row_rem_reg    <= '0;
            end else if (is_load) begin
                if (load_ok) begin
                    load_count_reg <= load_count_reg + CNT_W'(1);
                end
            end else if (is_req) begin
                m_tvalid_reg <= 1'b1;
                m_tlast_reg  <= last;
                if (col_wrap) begin
                    out_col_reg <= '0;
                    src_col_reg <= '0;
                    col_rem_reg <= '0;
                    if (last) begin
                        load_count_reg <= '0;
                        out_row_reg    <= '0;
                        src_row_reg    <= '0;
                        row_rem_reg    <= '0;
                    end else begin
                        out_row_reg <= out_row_reg + POS_W'(1);
                        src_row_reg <= src_row_next;
                        row_rem_reg <= row_rem_next;
                    end
                end else begin
                    out_col_reg <= out_col_reg + POS_W'(1);
                    src_col_reg <= src_col_next;
                    col_rem_reg <= col_rem_next;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = TDATA_W'(ram_rdata);

endmodule

`default_nettype wire
